// ===== sv/kmer_hit_run_segmenter_core_macros.svh =====
// Assertion macros for the k-mer hit run segmenter checker.
// Used by khrs_checker.sv only; no other dependencies.
`ifndef KMER_HIT_RUN_SEGMENTER_CORE_MACROS_SVH
`define KMER_HIT_RUN_SEGMENTER_CORE_MACROS_SVH

// Implication checked on every edge outside reset.
`define KHRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every edge outside reset.
`define KHRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/khrs_pkg.sv =====
// Shared types and constants for the k-mer hit run segmenter.
// No dependencies.
`timescale 1ns / 1ps

package khrs_pkg;

   localparam int NODE_BITS   = 32;
   localparam int KMER_BITS   = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_RUN      = 2'd0;
   localparam logic [1:0] KIND_UNMAPPED = 2'd1;
   localparam logic [1:0] KIND_EMPTY    = 2'd2;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_END    = 1'b1;

   typedef enum logic [1:0] {
      OP_HIT  = 2'd0,
      OP_MISS = 2'd1,
      OP_END  = 2'd2
   } op_type;

   typedef struct packed {
      logic                        cmd;
      logic                        found;
      logic [KMER_BITS-1:0]        kmer;
      logic signed [NODE_BITS-1:0] hit_node;
      logic signed [31:0]          hit_node_pos;
      logic [31:0]                 seq_pos;
      logic [31:0]                 query_id;
      logic [31:0]                 unique_in_node;
      logic [31:0]                 total_in_node;
   } req_type;

   typedef struct packed {
      logic [1:0]                  kind;
      logic                        last_of_sequence;
      logic [31:0]                 run_query_id;
      logic signed [NODE_BITS-1:0] run_node;
      logic [31:0]                 first_query_pos;
      logic [31:0]                 last_query_pos;
      logic signed [31:0]          first_graph_pos;
      logic signed [31:0]          last_graph_pos;
      logic [31:0]                 matched_count;
      logic [31:0]                 possible_count;
      logic [31:0]                 node_kmer_count;
      logic [KMER_BITS-1:0]        lost_kmer;
   } rsp_type;

   // Classified item as queued between front and back end.
   typedef struct packed {
      op_type                      op;
      logic [KMER_BITS-1:0]        kmer;
      logic [NODE_BITS-1:0]        node;
      logic [NODE_BITS-1:0]        node_mag;
      logic signed [31:0]          node_pos;
      logic [31:0]                 seq_pos;
      logic [31:0]                 query_id;
      logic [31:0]                 unique_in_node;
      logic [31:0]                 total_in_node;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

// ===== sv/kmer_hit_run_segmenter_core.sv =====
// A result passes through the queue and then the output register after its item is transferred.
// Throughput: one item per clock while no result waits on rsp_ready; the back end applies each item as it is taken.
// A four-entry queue parts front and back; the output register parts back and consumer.
// Reset (synchronous, active high) empties the queue, closes the open run and drops
// any pending result. Depends on khrs_pkg, khrs_front and khrs_back.
`timescale 1ns / 1ps

module kmer_hit_run_segmenter_core import khrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   queue_head_type head;
   logic           pop;

   khrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   khrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/khrs_front.sv =====
// Front end: classifies incoming lookup results and queues them.
// Depends on khrs_pkg.
`timescale 1ns / 1ps

module khrs_front import khrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output queue_head_type head,
   input  logic           pop
);

   entry_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]    count_ff, count_in;
   entry_type               new_entry;
   logic                    push;
   logic                    do_pop;

   always_comb begin
      new_entry.kmer           = req_data.kmer;
      new_entry.node           = req_data.hit_node;
      new_entry.node_mag       = req_data.hit_node[NODE_BITS-1] ?
                                 NODE_BITS'(-req_data.hit_node) : req_data.hit_node;
      new_entry.node_pos       = req_data.hit_node_pos;
      new_entry.seq_pos        = req_data.seq_pos;
      new_entry.query_id       = req_data.query_id;
      new_entry.unique_in_node = req_data.unique_in_node;
      new_entry.total_in_node  = req_data.total_in_node;
      if (req_data.cmd == CMD_END) begin
         new_entry.op = OP_END;
      end else if (req_data.found) begin
         new_entry.op = OP_HIT;
      end else begin
         new_entry.op = OP_MISS;
      end
   end

   assign req_ready  = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== sv/khrs_back.sv =====
// Back end: holds the open run, applies queued items and registers results.
// Depends on khrs_pkg.
`timescale 1ns / 1ps

module khrs_back import khrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   logic                 open_ff, open_in;
   logic [NODE_BITS-1:0] open_node_ff;
   logic [NODE_BITS-1:0] open_mag_ff;
   logic [31:0]          open_query_id_ff;
   logic [31:0]          open_first_qpos_ff;
   logic [31:0]          open_last_qpos_ff;
   logic signed [31:0]   open_first_gpos_ff;
   logic signed [31:0]   open_last_gpos_ff;
   logic [31:0]          open_matched_ff;
   logic [31:0]          open_possible_ff;
   logic [31:0]          open_node_kmers_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 continues;
   logic                 load_run;
   logic                 extend_run;
   logic                 has_result;
   rsp_type              run_record;

   entry_type e;
   assign e = head.entry;

   assign pop = head.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (open_mag_ff != e.node_mag) begin
         continues = 1'b0;
      end else if (open_last_gpos_ff > open_first_gpos_ff) begin
         continues = e.node_pos > open_last_gpos_ff;
      end else if (open_last_gpos_ff < open_first_gpos_ff) begin
         continues = e.node_pos < open_last_gpos_ff;
      end else begin
         continues = 1'b1;
      end
   end

   always_comb begin
      run_record.kind             = KIND_RUN;
      run_record.last_of_sequence = 1'b0;
      run_record.run_query_id     = open_query_id_ff;
      run_record.run_node         = open_node_ff;
      run_record.first_query_pos  = open_first_qpos_ff;
      run_record.last_query_pos   = open_last_qpos_ff;
      run_record.first_graph_pos  = open_first_gpos_ff;
      run_record.last_graph_pos   = open_last_gpos_ff;
      run_record.matched_count    = open_matched_ff;
      run_record.possible_count   = open_possible_ff;
      run_record.node_kmer_count  = open_node_kmers_ff;
      run_record.lost_kmer        = '0;
   end

   always_comb begin
      has_result  = 1'b0;
      load_run    = 1'b0;
      extend_run  = 1'b0;
      open_in     = open_ff;
      rsp_data_in = '0;
      rsp_data_in.run_query_id = e.query_id;
      case (e.op)
         OP_END: begin
            has_result = 1'b1;
            open_in    = 1'b0;
            if (open_ff) begin
               rsp_data_in = run_record;
            end else begin
               rsp_data_in.kind = KIND_EMPTY;
            end
            rsp_data_in.last_of_sequence = 1'b1;
         end
         OP_MISS: begin
            has_result            = 1'b1;
            rsp_data_in.kind      = KIND_UNMAPPED;
            rsp_data_in.lost_kmer = e.kmer;
         end
         OP_HIT: begin
            if (!open_ff) begin
               load_run = 1'b1;
            end else if (continues) begin
               extend_run = 1'b1;
            end else begin
               has_result  = 1'b1;
               rsp_data_in = run_record;
               load_run    = 1'b1;
            end
            // a run on node zero counts as no run at all
            if (load_run) begin
               open_in = (e.node != '0);
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
      rsp_valid_in = pop ? has_result : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            open_ff <= open_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && has_result) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (pop && load_run) begin
         open_node_ff       <= e.node;
         open_mag_ff        <= e.node_mag;
         open_query_id_ff   <= e.query_id;
         open_first_qpos_ff <= e.seq_pos;
         open_last_qpos_ff  <= e.seq_pos;
         open_first_gpos_ff <= e.node_pos;
         open_last_gpos_ff  <= e.node_pos;
         open_matched_ff    <= 32'd1;
         open_possible_ff   <= e.unique_in_node;
         open_node_kmers_ff <= e.total_in_node;
      end else if (pop && extend_run) begin
         // hold the count at all ones once full
         if (open_matched_ff != '1) begin
            open_matched_ff <= open_matched_ff + 32'd1;
         end
         open_last_gpos_ff <= e.node_pos;
         open_last_qpos_ff <= e.seq_pos;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/khrs_checker.sv =====
// Port-level checker for kmer_hit_run_segmenter_core, bound to the top level.
// Depends on khrs_pkg and kmer_hit_run_segmenter_core_macros.svh.
`timescale 1ns / 1ps
`include "kmer_hit_run_segmenter_core_macros.svh"

module khrs_checker import khrs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `KHRS_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data),
      "result dropped or changed while stalled")
   `KHRS_ASSERT_IMPL(a_run_nonzero, clock, reset,
      rsp_valid && rsp_data.kind == KIND_RUN,
      rsp_data.run_node != '0 && rsp_data.matched_count != '0,
      "run record without node or hits")
   `KHRS_ASSERT_IMPL(a_plain_clear, clock, reset,
      rsp_valid && (rsp_data.kind == KIND_UNMAPPED || rsp_data.kind == KIND_EMPTY),
      rsp_data.run_node == '0 && rsp_data.matched_count == '0,
      "run fields set on non-run result")
   `KHRS_ASSERT_IMPL(a_empty_last, clock, reset,
      rsp_valid && rsp_data.kind == KIND_EMPTY,
      rsp_data.last_of_sequence && rsp_data.lost_kmer == '0,
      "empty marker not flagged last")

endmodule

bind kmer_hit_run_segmenter_core khrs_checker u_khrs_checker (.*);
